@@ rtl/png_scanline_unfilter_rgba8_core_macros.svh @@
// assertion macros shared by the png scanline unfilter rtl
// no dependencies; compiled out when SYNTH is defined
`ifndef PNG_SCANLINE_UNFILTER_RGBA8_CORE_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_RGBA8_CORE_MACROS_SVH
`ifndef SYNTH
`define PNGU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pngu assertion failed");
`define PNGU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pngu assertion failed");
`else
`define PNGU_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PNGU_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/pngu_pkg.sv @@
// shared types and constants of the png scanline unfilter
// used by front, queue, back and top level
`default_nettype none
package pngu_pkg;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filt_type;

   // highest legal filter type byte
   localparam logic [7:0] FILT_CODE_MAX = 8'd4;

   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int WIDTH_CFG_W  = 11;
   localparam int HEIGHT_CFG_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_PIXELS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_ROWS  = 2'd1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // one word handed from front to back
   typedef struct packed {
      logic       bad;
      logic       first;
      logic       last;
      filt_type   filt;
      logic [7:0] x;
      logic [7:0] up;
   } item_type;

endpackage
`default_nettype wire

@@ rtl/pngu_ram.sv @@
// generic single-port-write ram with registered read
// no dependencies
`default_nettype none
module pngu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/pngu_front.sv @@
// front part: config registers, row/column tracking, filter byte decode,
// line buffer read issue; uses pngu_pkg
`default_nettype none
`include "png_scanline_unfilter_rgba8_core_macros.svh"
module pngu_front
   import pngu_pkg::*;
#(
   parameter int MAX_WIDTH   = 1024,
   parameter int PIXEL_BYTES = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire logic                   req_start_of_image,
   input  wire logic [7:0]             req_filtered_byte,
   output logic                        full,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [QUEUE_CNT_W-1:0] q_count,
   input  wire logic                   wr_done,
   output logic                        rd_en,
   output logic [((MAX_WIDTH * PIXEL_BYTES) > 1 ?
                  $clog2(MAX_WIDTH * PIXEL_BYTES) : 1)-1:0] rd_addr,
   input  wire logic [7:0]             rd_data,
   output logic                        push_valid,
   output item_type                    push_item
);

   localparam int ROW_CAP = MAX_WIDTH * PIXEL_BYTES;
   localparam int CW      = ROW_CAP > 1 ? $clog2(ROW_CAP) : 1;
   localparam int RBW     = $clog2(ROW_CAP + 1);
   localparam int WW      = $clog2(MAX_WIDTH + 1);
   localparam int PW      = $clog2(PIXEL_BYTES + 1);

   logic [RBW-1:0]          rb_ff, rb_in;
   logic [HEIGHT_CFG_W-1:0] rows_ff, rows_in;
   logic [CW-1:0]           col_ff, col_in;
   logic [15:0]             row_ff, row_in;
   filt_type                filt_ff, filt_in;
   logic                    await_ff, await_in;
   logic                    err_ff, err_in;
   logic [PW-1:0]           pend_ff, pend_in;
   logic                    s1_valid_ff, s1_valid_in;
   item_type                s1_item_ff, s1_item_in;
   logic                    s1_upv_ff, s1_upv_in;

   logic [WIDTH_CFG_W-1:0]  w_raw;
   logic [WW-1:0]           w_eff;
   logic [HEIGHT_CFG_W-1:0] h_raw;
   logic                    accept;
   logic [CW-1:0]           col_e;
   logic [15:0]             row_e;
   logic                    await_e, err_e;
   logic                    row_end, img_end;
   logic                    issue;
   logic [QUEUE_CNT_W-1:0]  q_load;

   // config: store the derived row length in bytes and clamped height
   always_comb begin
      w_raw = csr_wdata[WIDTH_CFG_W-1:0];
      h_raw = csr_wdata[HEIGHT_CFG_W-1:0];
      if (w_raw == '0) begin
         w_eff = WW'(1);
      end else if (32'(w_raw) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(w_raw);
      end
      rb_in   = rb_ff;
      rows_in = rows_ff;
      if (csr_we && csr_index == CSR_WIDTH_PIXELS) begin
         rb_in = RBW'(32'(w_eff) * PIXEL_BYTES);
      end
      if (csr_we && csr_index == CSR_HEIGHT_ROWS) begin
         rows_in = (h_raw == '0) ? HEIGHT_CFG_W'(1) : h_raw;
      end
   end

   // queue room is reserved for the word sitting in stage one
   assign q_load = q_count + QUEUE_CNT_W'(s1_valid_ff);
   // read of the byte above must not pass the write of the row before
   assign full   = (q_load >= QUEUE_CNT_W'(QUEUE_DEPTH)) ||
                   (pend_ff >= PW'(PIXEL_BYTES));
   assign accept = push && !full;

   always_comb begin
      col_e   = req_start_of_image ? '0 : col_ff;
      row_e   = req_start_of_image ? '0 : row_ff;
      await_e = req_start_of_image ? 1'b1 : await_ff;
      err_e   = req_start_of_image ? 1'b0 : err_ff;

      row_end = (RBW'(col_e) + RBW'(1)) >= rb_ff;
      img_end = row_end && ((17'(row_e) + 17'd1) >= 17'(rows_ff));

      col_in      = col_ff;
      row_in      = row_ff;
      filt_in     = filt_ff;
      await_in    = await_ff;
      err_in      = err_ff;
      issue       = 1'b0;
      s1_valid_in = 1'b0;
      s1_upv_in   = row_e != '0;
      s1_item_in  = '{bad: 1'b0, first: col_e == '0, last: img_end, filt: filt_ff,
                      x: req_filtered_byte, up: 8'h00};

      if (accept) begin
         col_in   = col_e;
         row_in   = row_e;
         await_in = await_e;
         err_in   = err_e;
         if (!err_e) begin
            if (await_e) begin
               if (req_filtered_byte > FILT_CODE_MAX) begin
                  err_in              = 1'b1;
                  s1_valid_in         = 1'b1;
                  s1_item_in.bad      = 1'b1;
                  s1_item_in.last     = 1'b0;
               end else begin
                  filt_in  = filt_type'(req_filtered_byte[2:0]);
                  await_in = 1'b0;
               end
            end else begin
               issue       = 1'b1;
               s1_valid_in = 1'b1;
               if (row_end) begin
                  row_in   = img_end ? '0 : row_e + 16'd1;
                  col_in   = '0;
                  await_in = 1'b1;
               end else begin
                  col_in = col_e + CW'(1);
               end
            end
         end
      end

      pend_in = pend_ff + PW'(issue) - PW'(wr_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rb_ff       <= RBW'(PIXEL_BYTES);
         rows_ff     <= HEIGHT_CFG_W'(1);
         col_ff      <= '0;
         row_ff      <= '0;
         filt_ff     <= FILT_NONE;
         await_ff    <= 1'b1;
         err_ff      <= 1'b0;
         pend_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         rb_ff       <= rb_in;
         rows_ff     <= rows_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         filt_ff     <= filt_in;
         await_ff    <= await_in;
         err_ff      <= err_in;
         pend_ff     <= pend_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      s1_upv_ff  <= s1_upv_in;
   end

   assign rd_en   = issue;
   assign rd_addr = col_e;

   always_comb begin
      push_item    = s1_item_ff;
      push_item.up = s1_upv_ff ? rd_data : 8'h00;
   end
   assign push_valid = s1_valid_ff;

   `PNGU_ASSERT_IMP(a_pend_bound, clock, reset, 1'b1, pend_ff <= PW'(PIXEL_BYTES))
   `PNGU_ASSERT_IMP(a_room, clock, reset, s1_valid_ff, q_count < QUEUE_CNT_W'(QUEUE_DEPTH))

endmodule
`default_nettype wire

@@ rtl/pngu_queue.sv @@
// short word queue between front and back
// uses pngu_pkg for the word type and depth
`default_nettype none
`include "png_scanline_unfilter_rgba8_core_macros.svh"
module pngu_queue
   import pngu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   input  item_type                    push_item,
   input  wire logic                   pop,
   output item_type                    head_item,
   output logic [QUEUE_CNT_W-1:0]      count
);

   item_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push_valid) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

   `PNGU_ASSERT_IMP(a_no_overrun, clock, reset, push_valid,
                    count_ff < QUEUE_CNT_W'(QUEUE_DEPTH))
   `PNGU_ASSERT_IMP(a_no_underrun, clock, reset, pop, count_ff != '0)

endmodule
`default_nettype wire

@@ rtl/pngu_back.sv @@
// back part: predictor, byte reconstruction, line buffer write, result register
// uses pngu_pkg
`default_nettype none
`include "png_scanline_unfilter_rgba8_core_macros.svh"
module pngu_back
   import pngu_pkg::*;
#(
   parameter int MAX_WIDTH   = 1024,
   parameter int PIXEL_BYTES = 4
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   q_empty,
   input  item_type    head_item,
   output logic        q_pop,
   output logic        wr_en,
   output logic [((MAX_WIDTH * PIXEL_BYTES) > 1 ?
                  $clog2(MAX_WIDTH * PIXEL_BYTES) : 1)-1:0] wr_addr,
   output logic [7:0]  wr_data,
   output logic        empty,
   input  wire logic   pop,
   output logic [7:0]  rsp_pixel_byte,
   output logic        rsp_last_of_image,
   output logic        rsp_bad_filter
);

   localparam int ROW_CAP = MAX_WIDTH * PIXEL_BYTES;
   localparam int CW      = ROW_CAP > 1 ? $clog2(ROW_CAP) : 1;
   localparam int LW      = 8 * PIXEL_BYTES;

   logic [LW-1:0] left_ff, left_in;
   logic [LW-1:0] upl_ff, upl_in;
   logic [CW-1:0] wcol_ff, wcol_in;
   logic          out_v_ff, out_v_in;
   logic [7:0]    pix_ff, pix_in;
   logic          last_ff, last_in;
   logic          bad_ff, bad_in;

   logic              take;
   logic [LW-1:0]     left_base, upl_base;
   logic [7:0]        a, b, c, pred, recon;
   logic [8:0]        avg_sum;
   logic signed [9:0] d_a, d_b, d_c;
   logic [9:0]        p_a, p_b, p_c;

   assign take = !q_empty && (!out_v_ff || pop);

   always_comb begin
      // a new row starts with empty left and upper-left history
      left_base = head_item.first ? '0 : left_ff;
      upl_base  = head_item.first ? '0 : upl_ff;
      a = left_base[LW-1 -: 8];
      c = upl_base[LW-1 -: 8];
      b = head_item.up;

      avg_sum = {1'b0, a} + {1'b0, b};
      d_a = $signed({2'b00, b}) - $signed({2'b00, c});
      d_b = $signed({2'b00, a}) - $signed({2'b00, c});
      d_c = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
      p_a = d_a[9] ? 10'(-d_a) : 10'(d_a);
      p_b = d_b[9] ? 10'(-d_b) : 10'(d_b);
      p_c = d_c[9] ? 10'(-d_c) : 10'(d_c);

      unique case (head_item.filt)
         FILT_NONE:  pred = 8'h00;
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = avg_sum[8:1];
         FILT_PAETH: begin
            if (p_a <= p_b && p_a <= p_c) begin
               pred = a;
            end else if (p_b <= p_c) begin
               pred = b;
            end else begin
               pred = c;
            end
         end
         default:    pred = 8'h00;
      endcase
      recon = head_item.x + pred;

      wr_en   = take && !head_item.bad;
      wr_addr = head_item.first ? '0 : wcol_ff + CW'(1);
      wr_data = recon;

      left_in = left_ff;
      upl_in  = upl_ff;
      wcol_in = wcol_ff;
      if (wr_en) begin
         left_in = (left_base << 8) | LW'(recon);
         upl_in  = (upl_base << 8) | LW'(b);
         wcol_in = wr_addr;
      end

      out_v_in = take ? 1'b1 : (pop ? 1'b0 : out_v_ff);
      pix_in   = pix_ff;
      last_in  = last_ff;
      bad_in   = bad_ff;
      if (take) begin
         pix_in  = head_item.bad ? 8'h00 : recon;
         last_in = head_item.bad ? 1'b0 : head_item.last;
         bad_in  = head_item.bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      upl_ff  <= upl_in;
      wcol_ff <= wcol_in;
      pix_ff  <= pix_in;
      last_ff <= last_in;
      bad_ff  <= bad_in;
   end

   assign q_pop             = take;
   assign empty             = !out_v_ff;
   assign rsp_pixel_byte    = pix_ff;
   assign rsp_last_of_image = last_ff;
   assign rsp_bad_filter    = bad_ff;

   `PNGU_ASSERT_NXT(a_bad_result, clock, reset, take && head_item.bad,
                    out_v_ff && bad_ff && !last_ff && pix_ff == 8'h00)
   `PNGU_ASSERT_IMP(a_first_col, clock, reset, wr_en && head_item.first, wr_addr == '0)

endmodule
`default_nettype wire

@@ rtl/png_scanline_unfilter_rgba8_core.sv @@
// PNG scanline unfilter for 8-bit RGBA: bytes of the inflated stream go in
// through push/full; each row's filter type byte is consumed silently and
// every data byte is rebuilt (None, Sub, Up, Average, Paeth) against a line
// buffer of the row above; reconstructed bytes leave through empty/pop, the
// last byte of the image flagged. A filter type above 4 yields one word with
// bad_filter set and mutes the stream until start_of_image. One byte is taken
// per clock while results are drained; the first result passes through the
// stage-one register, a queue slot and the result register. With PIXEL_BYTES
// below 3 the interlock between the line buffer read of the byte above and
// the write of the row before keeps data bytes from being taken every clock.
// No clearing pass after reset; registers are csr index 0 (width in pixels)
// and 1 (height in rows), and csr writes are always ready.
// depends on pngu_pkg, pngu_ram, pngu_front, pngu_queue, pngu_back
`default_nettype none
module png_scanline_unfilter_rgba8_core
   import pngu_pkg::*;
#(
   parameter int MAX_WIDTH   = 1024,
   parameter int PIXEL_BYTES = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire logic                  req_start_of_image,
   input  wire logic [7:0]            req_filtered_byte,
   output logic                       empty,
   input  wire logic                  pop,
   output logic [7:0]                 rsp_pixel_byte,
   output logic                       rsp_last_of_image,
   output logic                       rsp_bad_filter,
   input  wire logic                  valid,
   output logic                       ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ROW_CAP = MAX_WIDTH * PIXEL_BYTES;
   localparam int CW      = ROW_CAP > 1 ? $clog2(ROW_CAP) : 1;

   logic                   rd_en, wr_en;
   logic [CW-1:0]          rd_addr, wr_addr;
   logic [7:0]             rd_data, wr_data;
   logic                   push_valid, q_pop;
   item_type               push_item, head_item;
   logic [QUEUE_CNT_W-1:0] q_count;

   assign ready = 1'b1;

   pngu_ram #(
      .WIDTH (8),
      .DEPTH (ROW_CAP)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pngu_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .PIXEL_BYTES (PIXEL_BYTES)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .req_start_of_image (req_start_of_image),
      .req_filtered_byte  (req_filtered_byte),
      .full               (full),
      .csr_we             (valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .q_count            (q_count),
      .wr_done            (wr_en),
      .rd_en              (rd_en),
      .rd_addr            (rd_addr),
      .rd_data            (rd_data),
      .push_valid         (push_valid),
      .push_item          (push_item)
   );

   pngu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop        (q_pop),
      .head_item  (head_item),
      .count      (q_count)
   );

   pngu_back #(
      .MAX_WIDTH   (MAX_WIDTH),
      .PIXEL_BYTES (PIXEL_BYTES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_count == '0),
      .head_item         (head_item),
      .q_pop             (q_pop),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data),
      .empty             (empty),
      .pop               (pop),
      .rsp_pixel_byte    (rsp_pixel_byte),
      .rsp_last_of_image (rsp_last_of_image),
      .rsp_bad_filter    (rsp_bad_filter)
   );

endmodule
`default_nettype wire
